FILE: rtl/framed_packet_parser_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the framed packet parser
// Concurrent assertion wrappers; compiled out when ASSERT_OFF is defined.
// ---------------------------------------------------------------------------
`ifndef FRAMED_PACKET_PARSER_MACROS_SVH
`define FRAMED_PACKET_PARSER_MACROS_SVH

`ifndef ASSERT_OFF

`define FPP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define FPP_ASSERT_NEVER(label, clk, rst, cond, msg) \
   `FPP_ASSERT(label, clk, rst, !(cond), msg)

`else

`define FPP_ASSERT(label, clk, rst, prop, msg)

`define FPP_ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

FILE: rtl/fpp_pkg.sv
// ---------------------------------------------------------------------------
// Framed packet parser package
// Request/result types, command classification, parse states and codes.
// ---------------------------------------------------------------------------
package fpp_pkg;

   localparam logic [1:0] OP_BYTE    = 2'd0;
   localparam logic [1:0] OP_READ    = 2'd1;
   localparam logic [1:0] OP_RELEASE = 2'd2;

   localparam logic [2:0] EV_NONE     = 3'd0;
   localparam logic [2:0] EV_DONE     = 3'd1;
   localparam logic [2:0] EV_MISMATCH = 3'd2;
   localparam logic [2:0] EV_OVERRUN  = 3'd3;
   localparam logic [2:0] EV_BADLEN   = 3'd4;

   localparam logic [7:0] FRAME_OVERHEAD   = 8'd4;
   localparam logic [7:0] START_BYTE_RESET = 8'd153;

   // csr word index (paddr[2])
   localparam logic CSR_START_BYTE = 1'b0;

   localparam int MID_ADDR_W = 1;
   localparam int OUT_ADDR_W = 2;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] data_byte;
      logic [7:0] read_index;
   } req_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic        frame_ready;
      logic [7:0]  frame_length;
      logic [2:0]  event_res;
      logic [15:0] error_count;
      logic [15:0] overrun_count;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_BYTE,
      CMD_READ,
      CMD_RELEASE,
      CMD_NOP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   data_byte;
      logic [7:0]   read_index;
      logic         is_start;
      logic         len_bad;
      logic         len_zero;
      logic [7:0]   len_payload;
   } cmd_type;

   typedef enum logic [2:0] {
      PS_IDLE        = 3'd0,
      PS_GOT_START   = 3'd1,
      PS_IN_PAYLOAD  = 3'd2,
      PS_GOT_PAYLOAD = 3'd3,
      PS_GOT_CHECK1  = 3'd4
   } parse_state_type;

endpackage

FILE: rtl/fpp_fifo.sv
// ---------------------------------------------------------------------------
// Framed packet parser queue
// Small synchronous FIFO with occupancy count.
// ---------------------------------------------------------------------------
module fpp_fifo #(
   parameter type item_type = logic,
   parameter int  ADDR_W    = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  item_type          push_data,
   output logic              full,
   input  logic              pop,
   output item_type          pop_data,
   output logic              empty,
   output logic [ADDR_W:0]   count
);

   localparam int DEPTH = 2 ** ADDR_W;

   item_type          store_ff [DEPTH];
   logic [ADDR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ADDR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ADDR_W:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = (count_ff == (ADDR_W + 1)'(DEPTH));
   assign empty    = (count_ff == '0);
   assign count    = count_ff;
   assign pop_data = store_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/fpp_front.sv
// ---------------------------------------------------------------------------
// Framed packet parser front end
// Holds the start byte register and classifies each request into a command.
// ---------------------------------------------------------------------------
module fpp_front #(
   parameter int PAYLOAD_DEPTH = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  fpp_pkg::req_type req_data,
   output logic             cmd_push,
   output fpp_pkg::cmd_type cmd,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [2:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam logic [8:0] DEPTH_W = 9'(PAYLOAD_DEPTH);

   logic [7:0] start_ff, start_in;
   logic       csr_wr;
   logic [8:0] len_wide;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == fpp_pkg::CSR_START_BYTE);
   assign start_in   = csr_wr ? csr_pwdata[7:0] : start_ff;
   assign csr_prdata = (csr_paddr[2] == fpp_pkg::CSR_START_BYTE) ?
                       {24'd0, start_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= fpp_pkg::START_BYTE_RESET;
      end else begin
         start_ff <= start_in;
      end
   end

   assign len_wide = {1'b0, req_data.data_byte} - {1'b0, fpp_pkg::FRAME_OVERHEAD};

   always_comb begin
      cmd_push        = req_push;
      cmd.data_byte   = req_data.data_byte;
      cmd.read_index  = req_data.read_index;
      cmd.is_start    = (req_data.data_byte == start_ff);
      cmd.len_bad     = (req_data.data_byte < fpp_pkg::FRAME_OVERHEAD)
                        || (len_wide > DEPTH_W);
      cmd.len_zero    = (req_data.data_byte == fpp_pkg::FRAME_OVERHEAD);
      cmd.len_payload = len_wide[7:0];
      unique case (req_data.operation)
         fpp_pkg::OP_BYTE:    cmd.kind = fpp_pkg::CMD_BYTE;
         fpp_pkg::OP_READ:    cmd.kind = fpp_pkg::CMD_READ;
         fpp_pkg::OP_RELEASE: cmd.kind = fpp_pkg::CMD_RELEASE;
         default:             cmd.kind = fpp_pkg::CMD_NOP;
      endcase
   end

endmodule

FILE: rtl/fpp_back.sv
// ---------------------------------------------------------------------------
// Framed packet parser back end
// Parse state machine, running sums, payload memory and counters; two stages.
// ---------------------------------------------------------------------------
`include "framed_packet_parser_macros.svh"

module fpp_back #(
   parameter int PAYLOAD_DEPTH = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   input  fpp_pkg::cmd_type              cmd,
   output logic                          cmd_pop,
   input  logic [fpp_pkg::OUT_ADDR_W:0]  out_count,
   output logic                          rsp_push,
   output fpp_pkg::rsp_type              rsp
);

   localparam int         AW      = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
   localparam int         CW      = fpp_pkg::OUT_ADDR_W + 2;
   localparam logic [8:0] DEPTH_W = 9'(PAYLOAD_DEPTH);

   fpp_pkg::parse_state_type state_ff, state_in;
   logic [7:0]       exp_len_ff, exp_len_in;
   logic [7:0]       pos_ff, pos_in;
   logic [7:0]       sum1_ff, sum1_in;
   logic [7:0]       sum2_ff, sum2_in;
   logic             held_ff, held_in;
   logic [15:0]      err_ff, err_in;
   logic [15:0]      ovr_ff, ovr_in;
   logic [2:0]       ev;
   logic             go;
   logic             read_ok;
   logic             mem_we;
   logic [7:0]       sum1_add;
   logic [7:0]       pos_inc;
   logic [7:0]       payload_mem [PAYLOAD_DEPTH];
   logic [7:0]       mem_q_ff;
   logic             s2_valid_ff;
   logic             s2_rd_en_ff;
   fpp_pkg::rsp_type s2_rsp_ff, s2_rsp_in;

   assign go      = cmd_valid && ((CW'(out_count) + CW'(s2_valid_ff)) <
                    CW'(2 ** fpp_pkg::OUT_ADDR_W));
   assign cmd_pop = go;
   assign sum1_add = sum1_ff + cmd.data_byte;
   assign pos_inc  = pos_ff + 8'd1;

   always_comb begin
      state_in   = state_ff;
      exp_len_in = exp_len_ff;
      pos_in     = pos_ff;
      sum1_in    = sum1_ff;
      sum2_in    = sum2_ff;
      held_in    = held_ff;
      err_in     = err_ff;
      ovr_in     = ovr_ff;
      ev         = fpp_pkg::EV_NONE;
      read_ok    = 1'b0;
      mem_we     = 1'b0;
      if (go) begin
         unique case (cmd.kind)
            fpp_pkg::CMD_BYTE: begin
               unique case (state_ff)
                  fpp_pkg::PS_IDLE: begin
                     if (cmd.is_start) begin
                        state_in = fpp_pkg::PS_GOT_START;
                     end
                  end
                  fpp_pkg::PS_GOT_START: begin
                     priority if (held_ff) begin
                        ovr_in   = ovr_ff + 16'd1;
                        err_in   = err_ff + 16'd1;
                        state_in = fpp_pkg::PS_IDLE;
                        ev       = fpp_pkg::EV_OVERRUN;
                     end else if (cmd.len_bad) begin
                        err_in   = err_ff + 16'd1;
                        state_in = fpp_pkg::PS_IDLE;
                        ev       = fpp_pkg::EV_BADLEN;
                     end else begin
                        exp_len_in = cmd.len_payload;
                        sum1_in    = cmd.data_byte;
                        sum2_in    = cmd.data_byte;
                        pos_in     = 8'd0;
                        state_in   = cmd.len_zero ? fpp_pkg::PS_GOT_PAYLOAD :
                                     fpp_pkg::PS_IN_PAYLOAD;
                     end
                  end
                  fpp_pkg::PS_IN_PAYLOAD: begin
                     mem_we  = ({1'b0, pos_ff} < DEPTH_W);
                     sum1_in = sum1_add;
                     sum2_in = sum2_ff + sum1_add;
                     pos_in  = pos_inc;
                     if (pos_inc >= exp_len_ff) begin
                        state_in = fpp_pkg::PS_GOT_PAYLOAD;
                     end
                  end
                  fpp_pkg::PS_GOT_PAYLOAD: begin
                     if (cmd.data_byte != sum1_ff) begin
                        err_in   = err_ff + 16'd1;
                        state_in = fpp_pkg::PS_IDLE;
                        ev       = fpp_pkg::EV_MISMATCH;
                     end else begin
                        state_in = fpp_pkg::PS_GOT_CHECK1;
                     end
                  end
                  fpp_pkg::PS_GOT_CHECK1: begin
                     if (cmd.data_byte != sum2_ff) begin
                        err_in = err_ff + 16'd1;
                        ev     = fpp_pkg::EV_MISMATCH;
                     end else begin
                        held_in = 1'b1;
                        ev      = fpp_pkg::EV_DONE;
                     end
                     state_in = fpp_pkg::PS_IDLE;
                  end
                  default: begin
                     err_in   = err_ff + 16'd1;
                     state_in = fpp_pkg::PS_IDLE;
                  end
               endcase
            end
            fpp_pkg::CMD_READ: begin
               read_ok = held_ff && (cmd.read_index < exp_len_ff)
                         && ({1'b0, cmd.read_index} < DEPTH_W);
            end
            fpp_pkg::CMD_RELEASE: begin
               held_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      s2_rsp_in.read_data     = 8'd0;
      s2_rsp_in.frame_ready   = held_in;
      s2_rsp_in.frame_length  = held_in ? exp_len_in : 8'd0;
      s2_rsp_in.event_res     = ev;
      s2_rsp_in.error_count   = err_in;
      s2_rsp_in.overrun_count = ovr_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= fpp_pkg::PS_IDLE;
         exp_len_ff  <= 8'd0;
         pos_ff      <= 8'd0;
         sum1_ff     <= 8'd0;
         sum2_ff     <= 8'd0;
         held_ff     <= 1'b0;
         err_ff      <= 16'd0;
         ovr_ff      <= 16'd0;
         s2_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         exp_len_ff  <= exp_len_in;
         pos_ff      <= pos_in;
         sum1_ff     <= sum1_in;
         sum2_ff     <= sum2_in;
         held_ff     <= held_in;
         err_ff      <= err_in;
         ovr_ff      <= ovr_in;
         s2_valid_ff <= go;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         s2_rsp_ff   <= s2_rsp_in;
         s2_rd_en_ff <= read_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         payload_mem[pos_ff[AW-1:0]] <= cmd.data_byte;
      end
      if (read_ok) begin
         mem_q_ff <= payload_mem[cmd.read_index[AW-1:0]];
      end
   end

   always_comb begin
      rsp_push      = s2_valid_ff;
      rsp           = s2_rsp_ff;
      rsp.read_data = s2_rd_en_ff ? mem_q_ff : 8'd0;
   end

   `FPP_ASSERT_NEVER(a_no_write_while_held, clock, reset, mem_we && held_ff, "payload write while frame held")
   `FPP_ASSERT(a_read_reaches_s2, clock, reset, go && read_ok |=> s2_valid_ff && s2_rd_en_ff, "read lost before result stage")
   `FPP_ASSERT(a_err_step, clock, reset, !$past(reset) && !$stable(err_ff) |-> err_ff == $past(err_ff) + 16'd1, "error count jumped")
   `FPP_ASSERT(a_ovr_is_err, clock, reset, !$past(reset) && !$stable(ovr_ff) |-> !$stable(err_ff), "overrun not counted as error")

endmodule

FILE: rtl/framed_packet_parser.sv
// ---------------------------------------------------------------------------
// Framed packet parser
// Deframes a start/length/two-sum byte stream and serves the held payload.
// ---------------------------------------------------------------------------
// One request is accepted every cycle while the command queue has room;
// each gives exactly one result, in order, through the command queue and
// the back end's registered result stage. The front end classifies each
// request and feeds a two-entry command queue; the back end runs the
// parse state machine per request, reads the payload memory through a
// registered port and posts to a four-entry result queue, stalling only
// when full, counting a result in flight. The payload memory is
// not cleared after reset; a read only returns bytes of the frame now held.
`include "framed_packet_parser_macros.svh"

module framed_packet_parser #(
   parameter int PAYLOAD_DEPTH = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  fpp_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output fpp_pkg::rsp_type rsp_data,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [2:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic                           cmd_push;
   fpp_pkg::cmd_type               cmd_in;
   fpp_pkg::cmd_type               cmd_head;
   logic                           cmd_empty;
   logic                           cmd_pop;
   logic [fpp_pkg::MID_ADDR_W:0]   cmd_count;
   logic                           rsp_push;
   fpp_pkg::rsp_type               rsp_in;
   logic                           rsp_full;
   logic [fpp_pkg::OUT_ADDR_W:0]   rsp_count;

   fpp_front #(
      .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_data    (req_data),
      .cmd_push    (cmd_push),
      .cmd         (cmd_in),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   fpp_fifo #(
      .item_type (fpp_pkg::cmd_type),
      .ADDR_W    (fpp_pkg::MID_ADDR_W)
   ) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .full      (req_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_head),
      .empty     (cmd_empty),
      .count     (cmd_count)
   );

   fpp_back #(
      .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (!cmd_empty && (cmd_count != '0)),
      .cmd       (cmd_head),
      .cmd_pop   (cmd_pop),
      .out_count (rsp_count),
      .rsp_push  (rsp_push),
      .rsp       (rsp_in)
   );

   fpp_fifo #(
      .item_type (fpp_pkg::rsp_type),
      .ADDR_W    (fpp_pkg::OUT_ADDR_W)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_in),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty),
      .count     (rsp_count)
   );

   `FPP_ASSERT_NEVER(a_rsp_no_overflow, clock, reset, rsp_push && rsp_full, "result queue overflow")
   `FPP_ASSERT(a_rsp_count_bound, clock, reset, rsp_push |-> rsp_count < (fpp_pkg::OUT_ADDR_W + 1)'(2 ** fpp_pkg::OUT_ADDR_W), "result pushed without room")
   `FPP_ASSERT(a_pop_only_valid, clock, reset, cmd_pop |-> !cmd_empty, "command popped from empty queue")

endmodule
